### sv/bgba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgba_pkg: shared constants and types of the block group bitmap allocator
// Geometry of the group maps, memory word layout, operation and status codes.
// ----------------------------------------------------------------------------
package bgba_pkg;

  // File system geometry
  localparam int GROUPS       = 8;
  localparam int MAP_BITS     = 4096;
  localparam int GROUP_STRIDE = 32768;
  localparam int DATA_BASE    = 2051;
  localparam int DATA_QUOTA   = 4096;
  localparam int INODE_STRIDE = 32768;

  // Free counters
  localparam int CNT_W      = 13;
  localparam int COUNT_MAX  = 8191;
  localparam int QUOTA_INIT = (DATA_QUOTA > COUNT_MAX) ? COUNT_MAX : DATA_QUOTA;

  // Memory word layout: map position p of a group sits in word p/WORD_W, bit p%WORD_W
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WPG        = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int ISSUE_W    = $clog2(WPG + 1);
  localparam int LAST_BITS  = MAP_BITS - (WPG - 1) * WORD_W;
  localparam int RAM_DEPTH  = GROUPS * WPG;
  localparam int ADDR_W     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // Group index widths
  localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int GCNT_W = $clog2(GROUPS + 1);

  // Stream fields
  localparam int OP_W     = 2;
  localparam int GRP_IN_W = 3;
  localparam int IDX_W    = 18;
  localparam int ST_W     = 2;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC_DATA  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_INODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE_DATA   = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE    = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

  // Word search result
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_t;

endpackage
`default_nettype wire

### sv/block_group_bitmap_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_group_bitmap_allocator_top: ext2-style block and inode allocator
//
// Request words arrive on s_*, one response word per request leaves on m_*.
// Op 0 allocates a data block (first group with a nonzero free count, first
// fit in its map), op 1 allocates an inode in the named group, op 2 frees a
// data block. Both bitmaps live in RAMs of 64-bit words, 64 words per group.
// A search streams one word per cycle through the RAM read port. From the
// accepting edge to the edge that raises m_tvalid a data allocation passes
// a group step for each group tried (a group skipped for a zero count costs
// only that), a scan of the group's words up to a hit or the last word, and
// the response step; an inode allocation has no group step. A free passes a
// read step, a check step and the response step. One request is worked on at
// a time; s_tready is high only while the sequencer is idle.
// The response goes into an output register, so the next request is taken
// while a response is still held by a stalled receiver; the sequencer waits
// in its response step only when a second response finds the register full.
// After rst the maps are cleared by a pass over all 512 words (one word of
// each RAM per cycle) during which s_tready stays low; free counts reset to
// the quota at once.
// ----------------------------------------------------------------------------
module block_group_bitmap_allocator_top
  import bgba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // op [1:0], group [4:2], block [22:5], zero fill
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // status [1:0], index [19:2], zero fill
  output logic      [M_DATA_W-1:0] m_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_GSEL  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FCHK  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]            state;
  logic [ADDR_W-1:0]     clr_addr;
  logic [GCNT_W-1:0]     grp;
  logic                  is_inode;
  logic [ISSUE_W-1:0]    issue_cnt;
  logic                  chk_valid;
  logic [WORD_IDX_W-1:0] chk_word;
  logic [ADDR_W-1:0]     free_addr;
  logic [BIT_W-1:0]      free_bit;
  logic [GIDX_W-1:0]     free_grp;
  logic [ST_W-1:0]       res_status;
  logic [IDX_W-1:0]      res_index;
  logic [CNT_W-1:0]      cnt [GROUPS];

  // input fields
  logic [OP_W-1:0]     in_op;
  logic [GRP_IN_W-1:0] in_group;
  logic [IDX_W-1:0]    in_block;
  assign in_op    = s_tdata[1:0];
  assign in_group = s_tdata[4:2];
  assign in_block = s_tdata[22:5];

  logic s_acc;
  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // free request decode
  logic [31:0]       blk32, fg32, foff32, fpos32;
  logic              free_ok;
  logic [ADDR_W-1:0] free_addr_next;
  logic [BIT_W-1:0]  free_bit_next;
  always_comb begin
    blk32          = 32'(in_block);
    fg32           = blk32 / GROUP_STRIDE;
    foff32         = blk32 % GROUP_STRIDE;
    fpos32         = foff32 - 32'(DATA_BASE);
    free_ok        = (fg32 < 32'(GROUPS)) && (foff32 >= 32'(DATA_BASE)) &&
                     (fpos32 < 32'(MAP_BITS));
    free_addr_next = ADDR_W'(fg32 * 32'(WPG) + fpos32 / WORD_W);
    free_bit_next  = BIT_W'(fpos32 % WORD_W);
  end

  // memories
  logic              data_we, inode_we, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data, data_rdata, inode_rdata, scan_word;

  bgba_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  bgba_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_inode_ram (
    .clk   (clk),
    .we    (inode_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (inode_rdata)
  );

  assign scan_word = is_inode ? inode_rdata : data_rdata;

  // word search
  find_t fres;
  logic  last_word;
  assign last_word = (chk_word == WORD_IDX_W'(WPG - 1));

  bgba_find u_find (
    .word (scan_word),
    .last (last_word),
    .res  (fres)
  );

  // scan control
  logic              hit, exhausted, issue;
  logic [GIDX_W-1:0] grp_idx;
  logic [ADDR_W-1:0] issue_addr, chk_addr;
  assign grp_idx    = grp[GIDX_W-1:0];
  assign hit        = (state == S_SCAN) && chk_valid && fres.found;
  assign exhausted  = (state == S_SCAN) && chk_valid && !fres.found && last_word;
  assign issue      = (state == S_SCAN) && !hit && (issue_cnt < ISSUE_W'(WPG));
  assign issue_addr = ADDR_W'(32'(grp) * 32'(WPG) + 32'(issue_cnt[WORD_IDX_W-1:0]));
  assign chk_addr   = ADDR_W'(32'(grp) * 32'(WPG) + 32'(chk_word));
  assign rd_en      = issue || (state == S_FRD);
  assign rd_addr    = (state == S_SCAN) ? issue_addr : free_addr;

  // result index of a hit
  logic [31:0]      pos32, idx32;
  logic [IDX_W-1:0] hit_index;
  always_comb begin
    pos32 = 32'(chk_word) * 32'(WORD_W) + 32'(fres.bit_idx);
    if (is_inode) begin
      idx32 = 32'(grp) * 32'(INODE_STRIDE) + pos32;
    end else begin
      idx32 = 32'(grp) * 32'(GROUP_STRIDE) + 32'(DATA_BASE) + pos32;
    end
    hit_index = idx32[IDX_W-1:0];
  end

  // write port: clearing pass, set on allocation, clear on free
  logic free_set;
  assign free_set = data_rdata[free_bit];
  always_comb begin
    data_we  = 1'b0;
    inode_we = 1'b0;
    wr_addr  = chk_addr;
    wr_data  = scan_word;
    case (state)
      S_CLEAR: begin
        data_we  = 1'b1;
        inode_we = 1'b1;
        wr_addr  = clr_addr;
        wr_data  = '0;
      end
      S_SCAN: begin
        data_we                = hit && !is_inode;
        inode_we               = hit && is_inode;
        wr_data[fres.bit_idx]  = 1'b1;
      end
      S_FCHK: begin
        data_we            = free_set;
        wr_addr            = free_addr;
        wr_data            = data_rdata;
        wr_data[free_bit]  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      grp       <= '0;
      is_inode  <= 1'b0;
      issue_cnt <= '0;
      chk_valid <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        cnt[g] <= CNT_W'(QUOTA_INIT);
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(RAM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            res_index <= '0;
            is_inode  <= 1'b0;
            issue_cnt <= '0;
            chk_valid <= 1'b0;
            case (in_op)
              OP_ALLOC_DATA: begin
                grp   <= '0;
                state <= S_GSEL;
              end
              OP_ALLOC_INODE: begin
                if (32'(in_group) < 32'(GROUPS)) begin
                  grp      <= GCNT_W'(in_group);
                  is_inode <= 1'b1;
                  state    <= S_SCAN;
                end else begin
                  res_status <= ST_NONE;
                  state      <= S_RESP;
                end
              end
              OP_FREE_DATA: begin
                if (free_ok) begin
                  free_addr <= free_addr_next;
                  free_bit  <= free_bit_next;
                  free_grp  <= GIDX_W'(fg32);
                  state     <= S_FRD;
                end else begin
                  res_status <= ST_INVALID;
                  state      <= S_RESP;
                end
              end
              default: begin
                res_status <= ST_INVALID;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_GSEL: begin
          if (grp == GCNT_W'(GROUPS)) begin
            res_status <= ST_NONE;
            state      <= S_RESP;
          end else if (cnt[grp_idx] == '0) begin
            grp <= grp + 1'b1;
          end else begin
            issue_cnt <= '0;
            chk_valid <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_status <= ST_OK;
            res_index  <= hit_index;
            if (!is_inode) begin
              cnt[grp_idx] <= cnt[grp_idx] - 1'b1;
            end
            state <= S_RESP;
          end else if (exhausted) begin
            if (is_inode) begin
              res_status <= ST_NONE;
              state      <= S_RESP;
            end else begin
              grp   <= grp + 1'b1;
              state <= S_GSEL;
            end
          end else begin
            chk_valid <= issue;
            if (issue) begin
              chk_word  <= issue_cnt[WORD_IDX_W-1:0];
              issue_cnt <= issue_cnt + 1'b1;
            end
          end
        end
        S_FRD: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (free_set) begin
            res_status <= ST_OK;
            if (cnt[free_grp] != CNT_W'(COUNT_MAX)) begin
              cnt[free_grp] <= cnt[free_grp] + 1'b1;
            end
          end else begin
            res_status <= ST_INVALID;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  logic out_load;
  assign out_load = (state == S_RESP) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(M_DATA_W - IDX_W - ST_W)'(0), res_index, res_status};
    end
  end

  // checks
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !((data_we || inode_we) && rd_en && (wr_addr == rd_addr)))
    else $error("RAM write and read hit the same word");

  a_count_nonzero_on_alloc: assert property (@(posedge clk) disable iff (rst)
    (hit && !is_inode) |-> (cnt[grp_idx] != '0))
    else $error("data allocation from a group with zero free count");

  a_check_follows_read: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && chk_valid) |-> $past(rd_en))
    else $error("word checked without a read issued");

  a_index_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[19:2] == '0))
    else $error("nonzero index with failure status");

endmodule
`default_nettype wire

### sv/bgba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgba_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bgba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/bgba_find.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgba_find: first-fit search of one map word
// Bytes from low to high, inside a byte the highest bit first. Bits past the
// end of the map in the last word of a group count as taken.
// ----------------------------------------------------------------------------
module bgba_find
  import bgba_pkg::*;
(
  input  wire logic [WORD_W-1:0] word,
  input  wire logic              last,
  output find_t                  res
);

  localparam int NBYTES = WORD_W / 8;
  localparam int BSEL_W = (NBYTES > 1) ? $clog2(NBYTES) : 1;

  logic [WORD_W-1:0] occ;
  logic [NBYTES-1:0] byte_free;
  logic [BSEL_W-1:0] bsel;
  logic [7:0]        sel_byte;
  logic [2:0]        ksel;

  // mark the tail of the last word as occupied
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      occ[i] = word[i] | (last && (i >= LAST_BITS));
    end
  end

  // lowest byte holding a clear bit
  always_comb begin
    bsel = '0;
    for (int b = 0; b < NBYTES; b++) begin
      byte_free[b] = ~&occ[b*8 +: 8];
    end
    for (int b = NBYTES - 1; b >= 0; b--) begin
      if (byte_free[b]) begin
        bsel = BSEL_W'(b);
      end
    end
  end

  // highest clear bit in that byte
  always_comb begin
    ksel     = '0;
    sel_byte = occ[{bsel, 3'b000} +: 8];
    for (int k = 0; k < 8; k++) begin
      if (!sel_byte[k]) begin
        ksel = 3'(k);
      end
    end
  end

  assign res.found   = |byte_free;
  assign res.bit_idx = BIT_W'({bsel, ksel});

endmodule
`default_nettype wire
